@@ rtl/wdcs_pkg.sv @@
// package: constants, codes and helpers for the dual chain led serializer
package wdcs_pkg;

  localparam int PIXELS_PER_CHAIN = 6;
  localparam int PIXEL_COUNT      = 2 * PIXELS_PER_CHAIN;
  localparam int ADDR_W           = $clog2(PIXEL_COUNT);
  localparam int POS_W            = $clog2(PIXELS_PER_CHAIN + 1);
  localparam int BITS_PER_PIXEL   = 24;
  localparam int BIT_W            = 5;
  localparam int CNT_W            = 16;
  localparam int CFG_W            = 16;

  typedef logic [1:0] op_t;
  localparam op_t OP_WRITE   = 2'd0;
  localparam op_t OP_REFRESH = 2'd1;
  localparam op_t OP_TICK    = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SHORT_HIGH = 2'd0;
  localparam cfg_idx_t CFG_LONG_HIGH  = 2'd1;
  localparam cfg_idx_t CFG_RESET_LOW  = 2'd2;
  localparam cfg_idx_t CFG_LEDS       = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_GAP  = 2'd3
  } wave_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_LOAD = 3'b100
  } ctrl_state_t;

  function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
    at_least_one = (v == '0) ? CNT_W'(1) : v;
  endfunction

endpackage

@@ rtl/ws2812_dual_chain_serializer.sv @@
// top level: dual chain led serializer with pixel store in a synchronous memory
// sequence: write, refresh without pixels, op 3 and plain ticks go from idle to
//   the exec state, which finishes and sets the registered result strobe; a step
//   that loads a new pulse length reads the pixel memory and then passes through
//   the load state; a new request is taken only once the sequencer is idle again
// reset: synchronous, active low; registers to defaults, lines low, store reads zero
// the receiver cannot stall: the done strobe is high for one cycle only
module ws2812_dual_chain_serializer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [3:0]                  in_led_index,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  output logic                        done,
  output logic                        out_left_line,
  output logic                        out_right_line,
  output logic                        out_busy_res,
  output logic                        out_refresh_done,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [wdcs_pkg::CFG_W-1:0]  cfg_wdata
);
  import wdcs_pkg::*;

  // configuration
  logic [7:0]       short_high_r;
  logic [7:0]       long_high_r;
  logic [CNT_W-1:0] reset_low_r;
  logic [2:0]       leds_r;

  // control
  ctrl_state_t      state_r, state_nxt;
  op_t              op_r;
  logic [3:0]       idx_r;
  logic [23:0]      grb_r;

  // waveform state
  logic             chain_r, chain_nxt;
  logic [POS_W-1:0] pix_r, pix_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  wave_phase_t      phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             need_load;
  logic             rdone;
  logic             finish;

  // pixel memory
  logic [23:0]       mem [PIXEL_COUNT];
  logic [PIXEL_COUNT-1:0] vld_r;
  logic [23:0]       rd_data_r;
  logic              rd_vld_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              mem_we;
  logic [23:0]       rd_word;
  logic              cur_bit;

  // result registers
  logic done_r;
  logic left_r, right_r, busy_res_r, rdone_r;

  logic [POS_W-1:0] ppr;
  logic             accept;
  logic             is_busy;
  logic [POS_W-1:0] pix_inc;
  logic [BIT_W-1:0] bit_inc;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign is_busy = (phase_r != PH_IDLE);
  assign ppr     = (32'(leds_r) > PIXELS_PER_CHAIN) ? POS_W'(PIXELS_PER_CHAIN)
                                                     : POS_W'(leds_r);

  assign wr_addr = ADDR_W'(idx_r - 4'd1);
  assign mem_we  = (state_r == ST_EXEC) && (op_r == OP_WRITE) && !is_busy &&
                   (idx_r != 4'd0) && (32'(idx_r) <= PIXEL_COUNT);
  assign rd_addr = chain_nxt ? (ADDR_W'(PIXELS_PER_CHAIN) + ADDR_W'(pix_nxt))
                             : ADDR_W'(pix_nxt);
  assign rd_word = rd_vld_r ? rd_data_r : 24'd0;
  assign cur_bit = rd_word[5'd23 - bit_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_high_r <= 8'd20;
      long_high_r  <= 8'd42;
      reset_low_r  <= 16'd3300;
      leds_r       <= 3'd6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHORT_HIGH: short_high_r <= cfg_wdata[7:0];
        CFG_LONG_HIGH:  long_high_r  <= cfg_wdata[7:0];
        CFG_RESET_LOW:  reset_low_r  <= cfg_wdata[CNT_W-1:0];
        CFG_LEDS:       leds_r       <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= grb_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (mem_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      idx_r <= in_led_index;
      grb_r <= {in_green, in_red, in_blue};
    end
  end

  assign pix_inc = pix_r + POS_W'(1);
  assign bit_inc = bit_r + BIT_W'(1);

  always_comb begin
    state_nxt = state_r;
    chain_nxt = chain_r;
    pix_nxt   = pix_r;
    bit_nxt   = bit_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    need_load = 1'b0;
    rdone     = 1'b0;
    finish    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == OP_REFRESH) begin
          if (!is_busy) begin
            chain_nxt = 1'b0;
            pix_nxt   = '0;
            bit_nxt   = '0;
            if (ppr == '0) begin
              phase_nxt = PH_GAP;
              cnt_nxt   = at_least_one(reset_low_r);
            end else begin
              phase_nxt = PH_HIGH;
              need_load = 1'b1;
            end
          end
        end else if (op_r == OP_TICK) begin
          if (is_busy) begin
            if (cnt_r > CNT_W'(1)) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end else begin
              cnt_nxt = '0;
              unique case (phase_r)
                PH_HIGH: begin
                  phase_nxt = PH_LOW;
                  need_load = 1'b1;
                end
                PH_LOW: begin
                  if (32'(bit_inc) >= BITS_PER_PIXEL) begin
                    bit_nxt = '0;
                    pix_nxt = pix_inc;
                  end else begin
                    bit_nxt = bit_inc;
                  end
                  if (pix_nxt >= ppr) begin
                    phase_nxt = PH_GAP;
                    cnt_nxt   = at_least_one(reset_low_r);
                  end else begin
                    phase_nxt = PH_HIGH;
                    need_load = 1'b1;
                  end
                end
                PH_GAP: begin
                  pix_nxt = '0;
                  bit_nxt = '0;
                  if (!chain_r) begin
                    chain_nxt = 1'b1;
                    if (ppr == '0) begin
                      phase_nxt = PH_GAP;
                      cnt_nxt   = at_least_one(reset_low_r);
                    end else begin
                      phase_nxt = PH_HIGH;
                      need_load = 1'b1;
                    end
                  end else begin
                    chain_nxt = 1'b0;
                    phase_nxt = PH_IDLE;
                    rdone     = 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        if (need_load) begin
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_IDLE;
          finish    = 1'b1;
        end
      end
      ST_LOAD: begin
        if (phase_r == PH_HIGH) begin
          cnt_nxt = at_least_one(CNT_W'(cur_bit ? long_high_r : short_high_r));
        end else begin
          cnt_nxt = at_least_one(CNT_W'(cur_bit ? short_high_r : long_high_r));
        end
        state_nxt = ST_IDLE;
        finish    = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      chain_r    <= 1'b0;
      pix_r      <= '0;
      bit_r      <= '0;
      phase_r    <= PH_IDLE;
      cnt_r      <= '0;
      done_r     <= 1'b0;
      left_r     <= 1'b0;
      right_r    <= 1'b0;
      busy_res_r <= 1'b0;
      rdone_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      pix_r   <= pix_nxt;
      bit_r   <= bit_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= finish;
      if (finish) begin
        left_r     <= (phase_nxt == PH_HIGH) && !chain_nxt;
        right_r    <= (phase_nxt == PH_HIGH) && chain_nxt;
        busy_res_r <= (phase_nxt != PH_IDLE);
        rdone_r    <= rdone;
      end
    end
  end

  assign done             = done_r;
  assign out_left_line    = left_r;
  assign out_right_line   = right_r;
  assign out_busy_res     = busy_res_r;
  assign out_refresh_done = rdone_r;

  // results never come in adjacent cycles
  a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("result strobe on two adjacent cycles");

  // only one chain drives high at a time
  a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !(out_left_line && out_right_line))
    else $error("both data lines high");

  // end of refresh leaves the block idle with both lines low
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (done && out_refresh_done) |-> (!out_busy_res && !out_left_line && !out_right_line))
    else $error("refresh end with refresh still running");

  // a taken request always occupies the sequencer in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but sequencer idle");

endmodule
